// ===== src/assert_macros.svh =====
// Assertion macros shared by the set-toggle unit modules.
// Relies on clk and arst_n being visible in the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/llst_pkg.sv =====
// Shared types for the linked-list set toggle unit: codes, states and the
// command/status bundles between controller and datapath. No dependencies.
package llst_pkg;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_TOGGLE = 2'd1,
		ACT_DUMP   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_APPEND = 3'd0,
		ST_INSERT = 3'd1,
		ST_REMOVE = 3'd2,
		ST_FULL   = 3'd3,
		ST_DUMP   = 3'd4,
		ST_EMPTY  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD_TAIL,
		S_CAP_END,
		S_WALK_START,
		S_WALK,
		S_FOUND,
		S_ALLOC,
		S_LINK,
		S_ADD,
		S_FULL,
		S_DUMP_HEAD,
		S_DUMP_START,
		S_DUMP,
		S_EMPTY
	} state_t;

	// link memory read address source
	typedef enum logic [2:0] {
		RD_TAIL,
		RD_FREE,
		RD_HEAD,
		RD_LINK,
		RD_K
	} rd_sel_t;

	// link memory write: target <- data
	typedef enum logic [2:0] {
		LW_NONE,
		LW_INIT,
		LW_NODE_END,
		LW_TAIL_NODE,
		LW_P_NEXT,
		LW_K_FREE
	} lw_sel_t;

	typedef struct packed {
		rd_sel_t rd;
		lw_sel_t lw;
		logic    vw;
		logic    ld_in;
		logic    ld_end;
		logic    ld_walk;
		logic    step;
		logic    ld_node;
		logic    ld_free_rd;
		logic    free_k;
		logic    tail_node;
		logic    init_step;
		logic    emit;
		status_t res;
	} cmd_t;

	typedef struct packed {
		logic free_zero;
		logic k_end;
		logic k_zero;
		logic match;
		logic link_zero;
		logic out_free;
		logic init_last;
	} stat_t;

endpackage

// ===== src/llst_dp.sv =====
// Datapath of the set toggle unit: link and value memories, cursor registers
// and the output word register. Uses llst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llst_dp #(
	parameter int NODES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  llst_pkg::cmd_t   cmd,
	output llst_pkg::stat_t  st,
	input  logic [7:0]       in_value,
	input  logic             out_tready,
	output logic             out_tvalid,
	output logic [23:0]      out_tdata,
	output logic             out_tlast
);

	localparam int IW = $clog2(NODES);

	logic [IW-1:0] link_mem [NODES];
	logic [7:0]    val_mem  [NODES];

	logic [IW-1:0] link_rd_q;
	logic [7:0]    val_rd_q;

	logic [IW-1:0] tail_q, free_q, end_q, p_q, k_q, node_q, init_q;
	logic [7:0]    byte_q;

	logic [IW-1:0] rd_addr, wr_addr, wr_data, init_data;
	logic          wr_en;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [5:0]    out_index_q, out_link_q;
	logic [7:0]    out_value_q;
	logic          out_last_q;

	logic [IW-1:0] res_idx, res_lnk;
	logic [7:0]    res_val;
	logic [IW+5:0] res_idx_w, res_lnk_w;
	logic          out_free;

	assign out_free  = !out_valid_q || out_tready;
	assign init_data = (init_q == IW'(1) || init_q == IW'(NODES - 1)) ? '0 : init_q + IW'(1);

	always_comb begin
		unique case (cmd.rd)
			llst_pkg::RD_TAIL: rd_addr = tail_q;
			llst_pkg::RD_FREE: rd_addr = free_q;
			llst_pkg::RD_HEAD: rd_addr = IW'(1);
			llst_pkg::RD_LINK: rd_addr = link_rd_q;
			llst_pkg::RD_K:    rd_addr = k_q;
			default:           rd_addr = tail_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = init_q;
		wr_data = init_data;
		unique case (cmd.lw)
			llst_pkg::LW_NONE:      wr_en = 1'b0;
			llst_pkg::LW_INIT:      ;
			llst_pkg::LW_NODE_END: begin
				wr_addr = node_q;
				wr_data = end_q;
			end
			llst_pkg::LW_TAIL_NODE: begin
				wr_addr = tail_q;
				wr_data = node_q;
			end
			llst_pkg::LW_P_NEXT: begin
				wr_addr = p_q;
				wr_data = link_rd_q;
			end
			llst_pkg::LW_K_FREE: begin
				wr_addr = k_q;
				wr_data = free_q;
			end
			default:                wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.vw) begin
			val_mem[node_q] <= byte_q;
		end
		link_rd_q <= link_mem[rd_addr];
		val_rd_q  <= val_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q      <= IW'(1);
			free_q      <= IW'(2);
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_step) begin
				init_q <= init_q + IW'(1);
			end
			if (cmd.ld_free_rd) begin
				free_q <= link_rd_q;
			end
			// freed node goes to the head of the free chain
			if (cmd.free_k) begin
				free_q <= k_q;
				if (tail_q == k_q) begin
					tail_q <= p_q;
				end
			end
			if (cmd.tail_node) begin
				tail_q <= node_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			byte_q <= in_value;
		end
		if (cmd.ld_end) begin
			end_q <= link_rd_q;
		end
		if (cmd.ld_walk) begin
			k_q <= link_rd_q;
			p_q <= IW'(1);
		end
		if (cmd.step) begin
			p_q <= k_q;
			k_q <= link_rd_q;
		end
		if (cmd.ld_node) begin
			node_q <= free_q;
		end
		if (cmd.emit) begin
			out_status_q <= cmd.res;
			out_index_q  <= res_idx_w[5:0];
			out_value_q  <= res_val;
			out_link_q   <= res_lnk_w[5:0];
			out_last_q   <= !(cmd.res == llst_pkg::ST_DUMP && link_rd_q != '0);
		end
	end

	always_comb begin
		unique case (cmd.res)
			llst_pkg::ST_APPEND, llst_pkg::ST_INSERT: begin
				res_idx = node_q;
				res_val = byte_q;
				res_lnk = end_q;
			end
			llst_pkg::ST_REMOVE: begin
				res_idx = k_q;
				res_val = byte_q;
				res_lnk = end_q;
			end
			llst_pkg::ST_FULL: begin
				res_idx = '0;
				res_val = byte_q;
				res_lnk = '0;
			end
			llst_pkg::ST_DUMP: begin
				res_idx = k_q;
				res_val = val_rd_q;
				res_lnk = link_rd_q;
			end
			default: begin
				res_idx = '0;
				res_val = '0;
				res_lnk = '0;
			end
		endcase
	end

	assign res_idx_w = {6'd0, res_idx};
	assign res_lnk_w = {6'd0, res_lnk};

	assign st.free_zero = (free_q == '0);
	assign st.k_end     = (k_q == end_q);
	assign st.k_zero    = (k_q == '0);
	assign st.match     = (val_rd_q == byte_q);
	assign st.link_zero = (link_rd_q == '0);
	assign st.out_free  = out_free;
	assign st.init_last = (init_q == IW'(NODES - 1));

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {1'b0, out_link_q, out_value_q, out_index_q, out_status_q};
	assign out_tlast  = out_last_q;

	`ASSERT_IMP(a_tail_not_free_head, 1'b1, tail_q != '0)
	`ASSERT_IMP(a_free_skips_head, 1'b1, free_q != IW'(1))
	`ASSERT_IMP(a_emit_has_room, cmd.emit, out_free)

endmodule

// ===== src/llst_ctrl.sv =====
// Controller state machine of the set toggle unit: sequences memory reads,
// relinks and result words. Uses llst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_action,
	output logic            in_ready,
	input  llst_pkg::stat_t st,
	output llst_pkg::cmd_t  cmd
);

	llst_pkg::state_t state_q, state_d;
	logic append_q, append_d;
	logic acc;

	assign in_ready = (state_q == llst_pkg::S_IDLE);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= llst_pkg::S_INIT;
			append_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			append_q <= append_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		append_d = append_q;
		cmd      = '0;
		unique case (state_q)
			llst_pkg::S_INIT: begin
				cmd.lw        = llst_pkg::LW_INIT;
				cmd.init_step = 1'b1;
				if (st.init_last) begin
					state_d = llst_pkg::S_IDLE;
				end
			end
			llst_pkg::S_IDLE: begin
				if (acc) begin
					cmd.ld_in = 1'b1;
					append_d  = (in_action == llst_pkg::ACT_APPEND);
					unique case (in_action)
						llst_pkg::ACT_APPEND, llst_pkg::ACT_TOGGLE:
							state_d = llst_pkg::S_RD_TAIL;
						llst_pkg::ACT_DUMP:
							state_d = llst_pkg::S_DUMP_HEAD;
						default:
							state_d = llst_pkg::S_EMPTY;
					endcase
				end
			end
			llst_pkg::S_RD_TAIL: begin
				cmd.rd  = llst_pkg::RD_TAIL;
				state_d = llst_pkg::S_CAP_END;
			end
			llst_pkg::S_CAP_END: begin
				cmd.ld_end = 1'b1;
				if (append_q) begin
					state_d = llst_pkg::S_ALLOC;
				end else begin
					cmd.rd  = llst_pkg::RD_HEAD;
					state_d = llst_pkg::S_WALK_START;
				end
			end
			llst_pkg::S_WALK_START: begin
				cmd.ld_walk = 1'b1;
				cmd.rd      = llst_pkg::RD_LINK;
				state_d     = llst_pkg::S_WALK;
			end
			llst_pkg::S_WALK: begin
				// stop at the end of the first set or of the list, else test the byte
				priority if (st.k_end || st.k_zero) begin
					state_d = llst_pkg::S_ALLOC;
				end else if (st.match) begin
					cmd.lw     = llst_pkg::LW_P_NEXT;
					cmd.ld_end = 1'b1;
					state_d    = llst_pkg::S_FOUND;
				end else begin
					cmd.step = 1'b1;
					cmd.rd   = llst_pkg::RD_LINK;
				end
			end
			llst_pkg::S_FOUND: begin
				if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.res    = llst_pkg::ST_REMOVE;
					cmd.lw     = llst_pkg::LW_K_FREE;
					cmd.free_k = 1'b1;
					state_d    = llst_pkg::S_IDLE;
				end
			end
			llst_pkg::S_ALLOC: begin
				if (st.free_zero) begin
					state_d = llst_pkg::S_FULL;
				end else begin
					cmd.rd      = llst_pkg::RD_FREE;
					cmd.ld_node = 1'b1;
					state_d     = llst_pkg::S_LINK;
				end
			end
			llst_pkg::S_LINK: begin
				cmd.ld_free_rd = 1'b1;
				cmd.lw         = llst_pkg::LW_NODE_END;
				cmd.vw         = 1'b1;
				state_d        = llst_pkg::S_ADD;
			end
			llst_pkg::S_ADD: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.res       = append_q ? llst_pkg::ST_APPEND : llst_pkg::ST_INSERT;
					cmd.lw        = llst_pkg::LW_TAIL_NODE;
					cmd.tail_node = append_q;
					state_d       = llst_pkg::S_IDLE;
				end
			end
			llst_pkg::S_FULL: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = llst_pkg::ST_FULL;
					state_d  = llst_pkg::S_IDLE;
				end
			end
			llst_pkg::S_DUMP_HEAD: begin
				cmd.rd  = llst_pkg::RD_HEAD;
				state_d = llst_pkg::S_DUMP_START;
			end
			llst_pkg::S_DUMP_START: begin
				cmd.ld_walk = 1'b1;
				if (st.link_zero) begin
					state_d = llst_pkg::S_EMPTY;
				end else begin
					cmd.rd  = llst_pkg::RD_LINK;
					state_d = llst_pkg::S_DUMP;
				end
			end
			llst_pkg::S_DUMP: begin
				// hold the read on the current node while the output stalls
				cmd.rd = llst_pkg::RD_K;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = llst_pkg::ST_DUMP;
					cmd.step = 1'b1;
					cmd.rd   = llst_pkg::RD_LINK;
					if (st.link_zero) begin
						state_d = llst_pkg::S_IDLE;
					end
				end
			end
			llst_pkg::S_EMPTY: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = llst_pkg::ST_EMPTY;
					state_d  = llst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = llst_pkg::S_IDLE;
			end
		endcase
	end

	`ASSERT_NXT(a_accept_leaves_idle, acc, state_q != llst_pkg::S_IDLE)
	`ASSERT_NXT(a_init_holds, state_q == llst_pkg::S_INIT && !st.init_last, state_q == llst_pkg::S_INIT)
	`ASSERT_IMP(a_walk_only_toggle, state_q == llst_pkg::S_WALK, !append_q)

endmodule

// ===== src/linked_list_set_toggle_unit.sv =====
// Linked-list set toggle unit, top level. Append links a new node at the tail; toggle walks
// the first-set nodes and then removes the matching node or inserts the byte; dump lists
// every node; an unused action or an empty list gives an empty status, and a full store a
// full status. One item at a time, set by the serial walk over the single-read link memory;
// output stalls add cycles. After reset an init pass over every entry fills the link memory
// (free chain) with no item accepted.
module linked_list_set_toggle_unit #(
	parameter int NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // action[1:0], value[9:2], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // status[2:0], node_index[8:3],
	                                    // node_value[16:9], node_link[22:17]
	output logic        m_axis_tlast
);

	llst_pkg::cmd_t  cmd;
	llst_pkg::stat_t st;

	llst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tdata[1:0]),
		.in_ready  (s_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	llst_dp #(
		.NODES (NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_value   (s_axis_tdata[9:2]),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tlast  (m_axis_tlast)
	);

endmodule
